// ===== rtl/core/kchd_pkg.sv =====
// Package: types, constants and the per-key update function of the key click/hold detector.
`timescale 1ns / 1ps
`default_nettype none

package kchd_pkg;

  // Key count and derived widths
  localparam int NumKeys  = 8;
  localparam int KeyAddrW = (NumKeys > 1) ? $clog2(NumKeys) : 1;

  // Configuration register indexes
  localparam int CfgIdxW = 8;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESS_THR    = 8'd0,
    CFG_HOLD_THR     = 8'd1,
    CFG_INTERVAL_THR = 8'd2,
    CFG_MULTI_EN     = 8'd3
  } cfg_reg_e;

  localparam logic [15:0] PressThrRst    = 16'd20;
  localparam logic [15:0] HoldThrRst     = 16'd1000;
  localparam logic [15:0] IntervalThrRst = 16'd300;
  localparam logic        MultiEnRst     = 1'b0;

  // Per-key phase, one-hot
  typedef enum logic [6:0] {
    PH_RELEASE  = 7'b0000001,
    PH_DITHER   = 7'b0000010,
    PH_PRECLICK = 7'b0000100,
    PH_INCLICK  = 7'b0001000,
    PH_PRESS    = 7'b0010000,
    PH_HOLD     = 7'b0100000,
    PH_MULTI    = 7'b1000000
  } phase_e;

  // Phase codes as seen on the result
  localparam logic [2:0] CodeRelease  = 3'd0;
  localparam logic [2:0] CodeDither   = 3'd1;
  localparam logic [2:0] CodePreclick = 3'd2;
  localparam logic [2:0] CodeInclick  = 3'd3;
  localparam logic [2:0] CodePress    = 3'd4;
  localparam logic [2:0] CodeHold     = 3'd5;
  localparam logic [2:0] CodeMulti    = 3'd6;

  typedef struct packed {
    logic [15:0] press_thr;
    logic [15:0] hold_thr;
    logic [15:0] interval_thr;
    logic        multi_en;
  } cfg_t;

  typedef struct packed {
    logic multi;
    logic hold;
    logic pressed;
  } flags_t;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] held;
    logic [15:0] gap;
    logic [7:0]  clicks;
    flags_t      flags;
  } entry_t;

  localparam entry_t EntryRst = '{
    phase:  PH_RELEASE,
    held:   16'd0,
    gap:    16'd0,
    clicks: 8'd0,
    flags:  '0
  };

  typedef struct packed {
    logic                en;
    logic [KeyAddrW-1:0] addr;
    entry_t              data;
  } mem_wr_t;

  // Add with saturation at the 16-bit maximum
  function automatic logic [15:0] kchd_sat_add(logic [15:0] a, logic [7:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {9'd0, b};
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  // Increment with saturation at the 8-bit maximum
  function automatic logic [7:0] kchd_inc(logic [7:0] c);
    return (c == 8'hFF) ? 8'hFF : c + 8'd1;
  endfunction

  // Map the one-hot phase to its result code
  function automatic logic [2:0] kchd_state_code(phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_RELEASE:  code = CodeRelease;
      PH_DITHER:   code = CodeDither;
      PH_PRECLICK: code = CodePreclick;
      PH_INCLICK:  code = CodeInclick;
      PH_PRESS:    code = CodePress;
      PH_HOLD:     code = CodeHold;
      PH_MULTI:    code = CodeMulti;
      default:     code = CodeRelease;
    endcase
    return code;
  endfunction

  // One scan tick for one key: counters first, then the phase logic
  function automatic entry_t kchd_step(entry_t cur, logic lv, logic [7:0] t, cfg_t cfg);
    entry_t nxt;
    logic   keep_held;
    nxt       = cur;
    keep_held = (cur.phase == PH_DITHER) || (cur.phase == PH_HOLD);

    if (lv) begin
      nxt.held = kchd_sat_add(cur.held, t);
    end else if (!keep_held) begin
      nxt.held = 16'd0;
    end

    if ((cur.phase == PH_PRECLICK) || (cur.phase == PH_INCLICK)) begin
      nxt.gap = kchd_sat_add(cur.gap, t);
    end else begin
      nxt.gap = 16'd0;
    end

    case (cur.phase)
      PH_RELEASE: begin
        nxt.flags  = '0;
        nxt.clicks = 8'd0;
        if (lv) nxt.phase = PH_DITHER;
      end
      PH_DITHER: begin
        if (nxt.held > cfg.hold_thr) nxt.phase = PH_HOLD;
        if (!lv) begin
          if ((nxt.held > cfg.press_thr) && (nxt.held < cfg.hold_thr)) begin
            nxt.phase  = PH_PRECLICK;
            nxt.clicks = kchd_inc(cur.clicks);
          end else begin
            nxt.phase = PH_RELEASE;
          end
        end
      end
      PH_PRECLICK: begin
        if (cfg.multi_en && (nxt.gap < cfg.interval_thr)) begin
          if (nxt.held > cfg.press_thr) begin
            nxt.phase  = PH_MULTI;
            nxt.clicks = kchd_inc(cur.clicks);
          end
        end else begin
          nxt.phase = PH_PRESS;
        end
      end
      PH_INCLICK: begin
        if (nxt.gap < cfg.interval_thr) begin
          if (nxt.held > cfg.press_thr) begin
            nxt.phase  = PH_MULTI;
            nxt.clicks = kchd_inc(cur.clicks);
          end
        end else begin
          nxt.flags.multi = 1'b1;
          nxt.phase       = PH_RELEASE;
        end
      end
      PH_PRESS: begin
        nxt.flags.pressed = 1'b1;
        if (!lv) nxt.phase = PH_RELEASE;
      end
      PH_HOLD: begin
        if (!lv) begin
          nxt.flags.hold = 1'b1;
          nxt.phase      = PH_RELEASE;
        end
      end
      PH_MULTI: begin
        if (!lv) nxt.phase = PH_INCLICK;
      end
      default: begin
        nxt.phase = cur.phase;
      end
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kchd_if.sv =====
// Interfaces: scan tick input, result output and configuration write channels.
`timescale 1ns / 1ps
`default_nettype none

interface kchd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] key_index;
  logic       level;
  logic [7:0] elapsed;

  modport source (output valid, key_index, level, elapsed, input ready);
  modport sink   (input valid, key_index, level, elapsed, output ready);
endinterface

interface kchd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] key_id;
  logic       is_pressed;
  logic       is_hold;
  logic       is_multi_click;
  logic [7:0] click_count;
  logic [2:0] key_state;

  modport source (output valid, key_id, is_pressed, is_hold, is_multi_click, click_count,
                  key_state, input ready);
  modport sink   (input valid, key_id, is_pressed, is_hold, is_multi_click, click_count,
                  key_state, output ready);
endinterface

interface kchd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kchd_cfg_regs.sv =====
// Configuration registers: thresholds and multi-click enable.
`timescale 1ns / 1ps
`default_nettype none

module kchd_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  kchd_cfg_if.sink           cfg_i,
  output kchd_pkg::cfg_t     cfg_o
);
  import kchd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Always take a transfer
  assign cfg_i.ready = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_PRESS_THR:    cfg_d.press_thr    = cfg_i.data;
        CFG_HOLD_THR:     cfg_d.hold_thr     = cfg_i.data;
        CFG_INTERVAL_THR: cfg_d.interval_thr = cfg_i.data;
        CFG_MULTI_EN:     cfg_d.multi_en     = cfg_i.data[0];
        default:          cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{press_thr: PressThrRst, hold_thr: HoldThrRst,
                 interval_thr: IntervalThrRst, multi_en: MultiEnRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/kchd_state_mem.sv =====
// Per-key state memory: one write and one registered read port, valid bits per key.
`timescale 1ns / 1ps
`default_nettype none

module kchd_state_mem (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire kchd_pkg::mem_wr_t               wr_i,
  input  wire logic                            rd_en_i,
  input  wire logic [kchd_pkg::KeyAddrW-1:0]   rd_addr_i,
  output kchd_pkg::entry_t                     rd_data_o
);
  import kchd_pkg::*;

  entry_t               mem_q [NumKeys];
  logic   [NumKeys-1:0] valid_q;
  entry_t               rd_data_q;
  logic                 rd_valid_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Mark written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  // Unwritten entries read as the reset state
  assign rd_data_o = rd_valid_q ? rd_data_q : EntryRst;

endmodule

`default_nettype wire

// ===== rtl/core/key_click_hold_detector_core.sv =====
// Top level: key click/hold/multi-click detector with per-key state in memory.
//
//  channel  | dir | contents                                       | accept
//  ---------+-----+------------------------------------------------+------------------
//  in_i     | in  | key_index, level, elapsed                      | valid & ready
//  out_o    | out | key_id, flags, click_count, key_state          | valid & ready
//  cfg_i    | in  | index, data (press, hold, interval thr, enable)| valid & ready
//
// One tick per cycle while out_o is ready; ticks pass stage 1, then the output register.
// Stage 1 reads the key's entry from the state memory (registered read); stage 2 updates
// it, writes it back and loads the output register. A write that coincides with the read
// of the same key is forwarded. Reset clears the per-key valid bits at once, so no
// clearing pass is needed. An output stall holds stage 2 and then the input.
`timescale 1ns / 1ps
`default_nettype none

module key_click_hold_detector_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  kchd_in_if.sink    in_i,
  kchd_out_if.source out_o,
  kchd_cfg_if.sink   cfg_i
);
  import kchd_pkg::*;

  cfg_t                cfg;
  mem_wr_t             mem_wr;
  entry_t              rd_data;
  entry_t              cur_entry;
  entry_t              nxt_entry;
  entry_t              fwd_q;
  logic [KeyAddrW-1:0] rd_addr;
  logic                in_fire;
  logic                adv;
  logic                s1_in_range;

  logic       s1_valid_q;
  logic [2:0] s1_key_q;
  logic       s1_level_q;
  logic [7:0] s1_elapsed_q;
  logic       s1_fwd_q;

  logic       out_valid_q;
  logic [2:0] out_key_q;
  logic       out_pressed_q;
  logic       out_hold_q;
  logic       out_multi_q;
  logic [7:0] out_clicks_q;
  logic [2:0] out_state_q;

  kchd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  kchd_state_mem u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mem_wr),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Handshake and advance
  assign adv         = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || adv;
  assign in_fire     = in_i.valid && in_i.ready;
  assign rd_addr     = KeyAddrW'(in_i.key_index);
  assign s1_in_range = (int'(s1_key_q) < NumKeys);

  // Pick forwarded or stored entry, then update
  assign cur_entry = s1_fwd_q ? fwd_q : rd_data;
  assign nxt_entry = kchd_step(cur_entry, s1_level_q, s1_elapsed_q, cfg);

  // Write back
  assign mem_wr.en   = adv && s1_in_range;
  assign mem_wr.addr = KeyAddrW'(s1_key_q);
  assign mem_wr.data = nxt_entry;

  // Hold the last written entry for forwarding
  always_ff @(posedge clk_i) begin
    if (mem_wr.en) begin
      fwd_q <= nxt_entry;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        s1_fwd_q   <= mem_wr.en && (mem_wr.addr == rd_addr);
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_key_q     <= in_i.key_index;
      s1_level_q   <= in_i.level;
      s1_elapsed_q <= in_i.elapsed;
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload; out-of-range keys give zero flags, click count and state
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_key_q     <= s1_key_q;
      out_pressed_q <= s1_in_range && nxt_entry.flags.pressed;
      out_hold_q    <= s1_in_range && nxt_entry.flags.hold;
      out_multi_q   <= s1_in_range && nxt_entry.flags.multi;
      out_clicks_q  <= s1_in_range ? nxt_entry.clicks : 8'd0;
      out_state_q   <= s1_in_range ? kchd_state_code(nxt_entry.phase) : CodeRelease;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.key_id         = out_key_q;
  assign out_o.is_pressed     = out_pressed_q;
  assign out_o.is_hold        = out_hold_q;
  assign out_o.is_multi_click = out_multi_q;
  assign out_o.click_count    = out_clicks_q;
  assign out_o.key_state      = out_state_q;

  // Memory writes come only from an advancing stage 1 item
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_wr.en |-> s1_valid_q)
    else $error("state write without a stage 1 item");

  // A same-key write during the read must select the forwarded entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && mem_wr.en && (mem_wr.addr == rd_addr) |=> s1_fwd_q)
    else $error("missed forwarding of a coinciding write");

  // Stored phase stays one-hot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr.en |-> $onehot(mem_wr.data.phase))
    else $error("written phase is not one-hot");

  // A stalled stage 1 item keeps its key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_key_q))
    else $error("stage 1 item lost during stall");

endmodule

`default_nettype wire

// ===== tb/sv/kchd_click_checker.sv =====
// Checker: watches the tick, result and configuration channels, predicts and compares results.
`timescale 1ns / 1ps

module kchd_click_checker
  import kchd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // scan tick channel
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  in_key_i,
  input  logic        in_level_i,
  input  logic [7:0]  in_elapsed_i,
  // result channel
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  out_key_i,
  input  logic        out_pressed_i,
  input  logic        out_hold_i,
  input  logic        out_multi_i,
  input  logic [7:0]  out_clicks_i,
  input  logic [2:0]  out_state_i,
  // configuration channel
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // status towards the testbench top
  output int          fail_count_o,
  output int          pending_o,
  output int          ticks_o,
  output logic [6:0]  states_seen_o,
  output logic [2:0]  flags_seen_o,
  output logic [7:0]  peak_clicks_o
);

  typedef struct packed {
    logic [2:0] key_id;
    logic       pressed;
    logic       hold;
    logic       multi;
    logic [7:0] clicks;
    logic [2:0] state;
  } key_report_t;

  // Predicted per-key state and the live configuration
  logic [2:0]  key_phase  [NumKeys];
  logic [15:0] key_held   [NumKeys];
  logic [15:0] key_gap    [NumKeys];
  logic [7:0]  key_clicks [NumKeys];
  flags_t      key_flags  [NumKeys];
  cfg_t        cfg_now;

  key_report_t expected_reports[$];
  int          fails;
  int          ticks;
  logic [6:0]  states_seen;
  logic [2:0]  flags_seen;
  logic [7:0]  peak_clicks;

  function automatic logic [15:0] sat16(logic [15:0] a, logic [7:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {9'd0, b};
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  function automatic logic [7:0] bump8(logic [7:0] c);
    return (c == 8'hFF) ? c : c + 8'd1;
  endfunction

  // Advance one key by one scan tick and return what the block should report
  function automatic key_report_t advance_key(logic [2:0] k, logic lv, logic [7:0] t);
    logic [2:0]  ph;
    logic [15:0] held;
    logic [15:0] gap;
    logic [7:0]  cnt;
    flags_t      fl;
    key_report_t rep;
    rep        = '0;
    rep.key_id = k;
    if (int'(k) >= NumKeys) return rep;

    ph   = key_phase[k];
    held = key_held[k];
    gap  = key_gap[k];
    cnt  = key_clicks[k];
    fl   = key_flags[k];

    // Counters first
    if (!lv && ph != CodeDither && ph != CodeHold) held = 16'd0;
    if (lv) held = sat16(held, t);
    if (ph == CodePreclick || ph == CodeInclick) gap = sat16(gap, t);
    else gap = 16'd0;

    // Then the phase logic on the updated counters
    case (ph)
      CodeRelease: begin
        fl  = '0;
        cnt = 8'd0;
        if (lv) ph = CodeDither;
      end
      CodeDither: begin
        if (held > cfg_now.hold_thr) ph = CodeHold;
        if (!lv) begin
          if (held > cfg_now.press_thr && held < cfg_now.hold_thr) begin
            ph  = CodePreclick;
            cnt = bump8(cnt);
          end else begin
            ph = CodeRelease;
          end
        end
      end
      CodePreclick: begin
        if (cfg_now.multi_en && gap < cfg_now.interval_thr) begin
          if (held > cfg_now.press_thr) begin
            ph  = CodeMulti;
            cnt = bump8(cnt);
          end
        end else begin
          ph = CodePress;
        end
      end
      CodeInclick: begin
        if (gap < cfg_now.interval_thr) begin
          if (held > cfg_now.press_thr) begin
            ph  = CodeMulti;
            cnt = bump8(cnt);
          end
        end else begin
          fl.multi = 1'b1;
          ph       = CodeRelease;
        end
      end
      CodePress: begin
        fl.pressed = 1'b1;
        if (!lv) ph = CodeRelease;
      end
      CodeHold: begin
        if (!lv) begin
          fl.hold = 1'b1;
          ph      = CodeRelease;
        end
      end
      CodeMulti: begin
        if (!lv) ph = CodeInclick;
      end
      default: ;
    endcase

    key_phase[k]  = ph;
    key_held[k]   = held;
    key_gap[k]    = gap;
    key_clicks[k] = cnt;
    key_flags[k]  = fl;

    rep.pressed = fl.pressed;
    rep.hold    = fl.hold;
    rep.multi   = fl.multi;
    rep.clicks  = cnt;
    rep.state   = ph;
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_report_t got;
    key_report_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumKeys; i++) begin
        key_phase[i]  = CodeRelease;
        key_held[i]   = 16'd0;
        key_gap[i]    = 16'd0;
        key_clicks[i] = 8'd0;
        key_flags[i]  = '0;
      end
      cfg_now.press_thr    = PressThrRst;
      cfg_now.hold_thr     = HoldThrRst;
      cfg_now.interval_thr = IntervalThrRst;
      cfg_now.multi_en     = MultiEnRst;
      expected_reports.delete();
      fails       = 0;
      ticks       = 0;
      states_seen = '0;
      flags_seen  = '0;
      peak_clicks = '0;
    end else begin
      // Track configuration writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_PRESS_THR:    cfg_now.press_thr    = cfg_data_i;
          CFG_HOLD_THR:     cfg_now.hold_thr     = cfg_data_i;
          CFG_INTERVAL_THR: cfg_now.interval_thr = cfg_data_i;
          CFG_MULTI_EN:     cfg_now.multi_en     = cfg_data_i[0];
          default: ;
        endcase
      end

      // Compare each result transfer against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        got = '{out_key_i, out_pressed_i, out_hold_i, out_multi_i, out_clicks_i, out_state_i};
        if (expected_reports.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] unexpected result: key=%0d state=%0d clicks=%0d", $realtime,
                     got.key_id, got.state, got.clicks);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display({"[%0t] mismatch: expected key=%0d p=%0b h=%0b m=%0b clicks=%0d ",
                        "state=%0d, got key=%0d p=%0b h=%0b m=%0b clicks=%0d state=%0d"},
                       $realtime, want.key_id, want.pressed, want.hold, want.multi,
                       want.clicks, want.state, got.key_id, got.pressed, got.hold,
                       got.multi, got.clicks, got.state);
          end
          if (want.state < 7) states_seen[want.state] = 1'b1;
          flags_seen = flags_seen | {want.multi, want.hold, want.pressed};
          if (want.clicks > peak_clicks) peak_clicks = want.clicks;
        end
      end

      // Predict the result of each tick transfer
      if (in_valid_i && in_ready_i) begin
        expected_reports.push_back(advance_key(in_key_i, in_level_i, in_elapsed_i));
        ticks++;
      end
    end

    fail_count_o  <= fails;
    pending_o     <= expected_reports.size();
    ticks_o       <= ticks;
    states_seen_o <= states_seen;
    flags_seen_o  <= flags_seen;
    peak_clicks_o <= peak_clicks;
  end

endmodule

// ===== tb/sv/tb_key_click_hold_detector_core.sv =====
// Testbench top: stimulus, configuration phases and verdict for the key click/hold detector.
`timescale 1ns / 1ps

module tb_key_click_hold_detector_core;
  import kchd_pkg::*;

  logic clk_i;
  logic rst_ni;

  kchd_in_if  in_if ();
  kchd_out_if out_if ();
  kchd_cfg_if cfg_if ();

  int         fail_count;
  int         pending;
  int         ticks;
  logic [6:0] states_seen;
  logic [2:0] flags_seen;
  logic [7:0] peak_clicks;

  // Traffic shaping
  bit idle_on;
  bit hold_off_req;

  // Per-key press/release plan for the random part
  logic       plan_level [NumKeys];
  int         plan_left  [NumKeys];
  logic [7:0] plan_tmax  [NumKeys];
  logic [2:0] last_key;

  key_click_hold_detector_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  kchd_click_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_ready_i    (in_if.ready),
    .in_key_i      (in_if.key_index),
    .in_level_i    (in_if.level),
    .in_elapsed_i  (in_if.elapsed),
    .out_valid_i   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .out_key_i     (out_if.key_id),
    .out_pressed_i (out_if.is_pressed),
    .out_hold_i    (out_if.is_hold),
    .out_multi_i   (out_if.is_multi_click),
    .out_clicks_i  (out_if.click_count),
    .out_state_i   (out_if.key_state),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_index_i   (cfg_if.index),
    .cfg_data_i    (cfg_if.data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .ticks_o       (ticks),
    .states_seen_o (states_seen),
    .flags_seen_o  (flags_seen),
    .peak_clicks_o (peak_clicks)
  );

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Offer one scan tick, with an occasional idle burst first, and hold until its transfer
  task automatic send_tick(logic [2:0] k, logic lv, logic [7:0] t);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.key_index <= k;
    in_if.level     <= lv;
    in_if.elapsed   <= t;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Drop the tick channel and wait for every outstanding result, plus pipeline slack
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all four registers on an idle block
  task automatic apply_setting(cfg_t c);
    cfg_reg_e    regs [4];
    logic [15:0] vals [4];
    regs = '{CFG_PRESS_THR, CFG_HOLD_THR, CFG_INTERVAL_THR, CFG_MULTI_EN};
    vals = '{c.press_thr, c.hold_thr, c.interval_thr,
             {15'($urandom_range(0, 32767)), c.multi_en}};
    wait_drained();
    cfg_if.valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_if.index <= regs[i];
      cfg_if.data  <= vals[i];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Random traffic: mostly per-key press/release runs, some noise
  task automatic random_ticks(int count, bit allow_long);
    logic [2:0] k;
    int         pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_tick(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
      end else begin
        k = ($urandom_range(0, 1) == 1) ? last_key : 3'($urandom_range(0, 7));
        if (plan_left[k] == 0) begin
          // flip the level and choose how long and how fast the next run is
          plan_level[k] = ~plan_level[k];
          pick          = $urandom_range(0, 9);
          if (pick < 4) begin
            plan_left[k] = $urandom_range(1, 3);
            plan_tmax[k] = 8'd20;
          end else if (pick < 7) begin
            plan_left[k] = $urandom_range(1, 4);
            plan_tmax[k] = 8'd120;
          end else if (pick < 9 || !allow_long) begin
            plan_left[k] = $urandom_range(2, 8);
            plan_tmax[k] = 8'd255;
          end else begin
            plan_left[k] = $urandom_range(260, 300);
            plan_tmax[k] = 8'd255;
          end
        end
        plan_left[k]--;
        send_tick(k, plan_level[k], 8'($urandom_range(0, plan_tmax[k])));
        last_key = k;
      end
    end
  endtask

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_if.ready <= 1'b0;
        for (int c = 0; c < 120; c++) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Run timed out with %0d results outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    cfg_t c;
    idle_on         = 1'b1;
    hold_off_req    = 1'b0;
    last_key        = 3'd0;
    for (int i = 0; i < NumKeys; i++) begin
      plan_level[i] = 1'b0;
      plan_left[i]  = 0;
      plan_tmax[i]  = 8'd0;
    end
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.key_index <= '0;
    in_if.level     <= 1'b0;
    in_if.elapsed   <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset configuration: a single click leading to a press
    send_tick(3'd0, 1'b1, 8'd10);
    send_tick(3'd0, 1'b1, 8'd15);
    send_tick(3'd0, 1'b0, 8'd0);
    send_tick(3'd0, 1'b0, 8'd5);
    send_tick(3'd0, 1'b1, 8'd8);
    send_tick(3'd0, 1'b0, 8'd0);
    send_tick(3'd0, 1'b0, 8'd0);
    // long hold and its release, then a dither released past the hold time
    repeat (5) send_tick(3'd7, 1'b1, 8'd255);
    send_tick(3'd7, 1'b0, 8'd0);
    send_tick(3'd7, 1'b1, 8'd1);
    send_tick(3'd7, 1'b0, 8'd0);
    // press exactly at the press threshold, and held exactly to the hold threshold
    send_tick(3'd3, 1'b1, 8'd20);
    send_tick(3'd3, 1'b0, 8'd0);
    repeat (4) send_tick(3'd4, 1'b1, 8'd250);
    send_tick(3'd4, 1'b0, 8'd0);

    // Multi-click enabled, with a long receiver hold-off and a sender pause
    apply_setting('{16'd20, 16'd1000, 16'd300, 1'b1});
    random_ticks(100, 1'b0);
    hold_off_req <= 1'b1;
    random_ticks(150, 1'b0);
    wait_drained();
    random_ticks(80, 1'b0);

    // All thresholds at the bottom
    apply_setting('{16'd0, 16'd0, 16'd0, 1'b0});
    random_ticks(100, 1'b0);

    // Wide windows: saturate the click count, the gap and the held time
    apply_setting('{16'd0, 16'hFFFF, 16'hFFFF, 1'b1});
    for (int n = 0; n < 540; n++) send_tick(3'd2, ~n[0], 8'($urandom_range(1, 255)));
    send_tick(3'd5, 1'b1, 8'd10);
    send_tick(3'd5, 1'b0, 8'd0);
    repeat (270) send_tick(3'd5, 1'b0, 8'd255);
    repeat (270) send_tick(3'd4, 1'b1, 8'd255);
    random_ticks(50, 1'b1);

    // All thresholds at the top
    apply_setting('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
    random_ticks(80, 1'b1);

    // Random settings; the last one without idling
    for (int p = 0; p < 3; p++) begin
      c.press_thr    = 16'($urandom_range(0, 60));
      c.hold_thr     = 16'($urandom_range(100, 1500));
      c.interval_thr = 16'($urandom_range(0, 700));
      c.multi_en     = 1'($urandom_range(0, 1));
      apply_setting(c);
      if (p == 2) idle_on = 1'b0;
      random_ticks(100, 1'b0);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d scan ticks over the reset setting and seven written ones",
             ticks);
    $display("States seen %b, flags seen %b, peak click count %0d, %0d mismatches",
             states_seen, flags_seen, peak_clicks, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
